/* hw/rtl/mtcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion trigger channel mapper package
// Shared types and constants: behavior entry layout, mode and item codes,
// register indexes and value constants.
// ----------------------------------------------------------------------------
package mtcm_pkg;

  // Item kinds carried on the input channel.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS    = 1'd1;

  // Behavior modes.
  localparam logic [3:0] MODE_X        = 4'd0;
  localparam logic [3:0] MODE_Y        = 4'd1;
  localparam logic [3:0] MODE_Z        = 4'd2;
  localparam logic [3:0] MODE_ACTIVE   = 4'd3;
  localparam logic [3:0] MODE_INACTIVE = 4'd4;
  localparam logic [3:0] MODE_SIDE_A   = 4'd5;
  localparam logic [3:0] MODE_BOTTOM   = 4'd10;

  // Stored orientation of an entry that has not seen a side yet.
  localparam logic [2:0] ORIENT_NONE = 3'd7;

  // Value constants.
  localparam logic signed [15:0] AXIS_LIMIT_POS = 16'sd250;
  localparam logic signed [15:0] AXIS_LIMIT_NEG = -16'sd250;
  localparam logic signed [10:0] AXIS_OFFSET    = 11'sd500;
  localparam logic [9:0]         FULL_VALUE     = 10'd1000;
  localparam logic [15:0]        PULSE_MS_RESET = 16'd100;

  // One behavior entry as held in the table memory.
  typedef struct packed {
    logic [3:0]  mode;
    logic [5:0]  channel;
    logic        momentary;
    logic        latch;
    logic [2:0]  orient;
    logic [31:0] start;
  } entry_t;

endpackage

/* hw/rtl/motion_trigger_channel_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion trigger channel mapper
// Maps accelerometer readings and events to channel values through a table
// of behavior entries, walked on each tick one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ---------------------------------
//  in        sink       in_valid_i/in_stall_o  func, entry fields, sensor fields
//  out       source     out_valid_o/out_stall_i out_channel, out_value, last
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index, cfg_data
//
//  A load transaction leaves the block idle and produces nothing.
//  A tick transaction occupies the block after acceptance until n entries are
//  walked, where n is list_length limited to MAX_ENTRIES: the table memory,
//  read one entry ahead and written back one entry behind, and the shared
//  elapsed-time compare handle one entry per cycle unless the output stalls.
//  Output stall freezes the walk; the output register lets the next input
//  be accepted while the final result is still waiting.
//  Reset leaves the table contents undefined; there is no clearing pass.
//
module motion_trigger_channel_mapper #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [5:0]                    entry_index_i,
  input  logic [3:0]                    entry_mode_i,
  input  logic [5:0]                    entry_channel_i,
  input  logic                          entry_momentary_i,
  input  logic signed [15:0]            accel_x_i,
  input  logic signed [15:0]            accel_y_i,
  input  logic signed [15:0]            accel_z_i,
  input  logic                          inactivity_irq_i,
  input  logic                          activity_irq_i,
  input  logic [2:0]                    up_side_i,
  input  logic [31:0]                   now_ms_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    out_channel_o,
  output logic [9:0]                    out_value_o,
  output logic                          last_o,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mtcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import mtcm_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  // Control state
  logic             state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [6:0]       list_length_q;
  logic [15:0]      pulse_ms_q;
  logic             is_active_q, is_active_d;
  logic             is_inactive_q, is_inactive_d;
  logic             out_valid_q, out_valid_d;

  // Tick payload, held for the whole walk
  logic signed [15:0] accel_x_q, accel_y_q, accel_z_q;
  logic [2:0]         side_q;
  logic [31:0]        now_q;

  // Output payload
  logic [5:0] out_channel_q;
  logic [9:0] out_value_q;
  logic       last_q;

  // Table memory
  entry_t           entry_mem_q [MAX_ENTRIES];
  entry_t           rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             in_accept;
  logic             load_accept;
  logic             tick_accept;
  logic             step;
  logic             at_last;
  logic [CNT_W-1:0] n_sel;

  // Evaluation datapath
  entry_t             upd;
  logic [9:0]         val;
  logic signed [15:0] axis_raw;
  logic signed [15:0] axis_sat;
  logic signed [10:0] axis_sum;
  logic [31:0]        elapsed;
  logic               pulse_live;
  logic               trig;
  logic               cond;
  logic               already;
  logic [2:0]         target;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign load_accept = in_accept && (func_i == FUNC_LOAD);
  assign tick_accept = in_accept && (func_i == FUNC_TICK);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign out_value_o   = out_value_q;
  assign last_o        = last_q;

  // Entries walked per tick, limited to the table depth.
  assign n_sel = (32'(list_length_q) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(list_length_q);

  // The walk advances when the output register is free or being emptied.
  assign step    = (state_q == S_EVAL) && (!out_valid_q || !out_stall_i);
  assign at_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_length_q <= '0;
      pulse_ms_q    <= PULSE_MS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LIST_LENGTH: list_length_q <= cfg_data_i[6:0];
        REG_PULSE_MS:    pulse_ms_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared evaluation unit: one entry per cycle unless stalled, including the
  // elapsed-time subtract and compare of the one-shot pulse.
  always_comb begin
    upd      = rdata_q;
    val      = '0;
    axis_raw = accel_x_q;
    axis_sat = '0;
    axis_sum = '0;
    trig     = 1'b0;
    cond     = 1'b0;
    already  = 1'b0;
    target   = 3'(rdata_q.mode - MODE_SIDE_A);
    elapsed  = now_q - rdata_q.start;
    pulse_live = (elapsed <= {16'b0, pulse_ms_q});

    priority if (rdata_q.mode <= MODE_Z) begin
      unique case (rdata_q.mode)
        MODE_X:  axis_raw = accel_x_q;
        MODE_Y:  axis_raw = accel_y_q;
        default: axis_raw = accel_z_q;
      endcase
      if (axis_raw > AXIS_LIMIT_POS) begin
        axis_sat = AXIS_LIMIT_POS;
      end else if (axis_raw < AXIS_LIMIT_NEG) begin
        axis_sat = AXIS_LIMIT_NEG;
      end else begin
        axis_sat = axis_raw;
      end
      axis_sum = $signed({axis_sat[9:0], 1'b0}) + AXIS_OFFSET;
      val      = axis_sum[9:0];
    end else if (rdata_q.mode == MODE_ACTIVE || rdata_q.mode == MODE_INACTIVE) begin
      trig    = 1'b1;
      cond    = (rdata_q.mode == MODE_ACTIVE) ? is_active_q : is_inactive_q;
      already = rdata_q.latch;
      if (!cond) begin
        upd.latch = 1'b0;
      end else if (rdata_q.momentary) begin
        upd.latch = 1'b1;
      end
    end else if (rdata_q.mode <= MODE_BOTTOM) begin
      trig    = 1'b1;
      cond    = (side_q == target);
      already = (rdata_q.orient == target);
      if (!cond) begin
        upd.orient = side_q;
      end else if (rdata_q.momentary) begin
        upd.orient = target;
      end
    end else begin
      val = '0;
    end

    // Trigger output: level, first pulse tick or timed pulse.
    if (trig && cond) begin
      if (!rdata_q.momentary) begin
        val = FULL_VALUE;
      end else if (!already) begin
        upd.start = now_q;
        val       = FULL_VALUE;
      end else begin
        val = pulse_live ? FULL_VALUE : 10'd0;
      end
    end
  end

  // Memory port selection.
  always_comb begin
    rd_en   = (state_q == S_IDLE) || step;
    rd_addr = (state_q == S_IDLE) ? '0 : IDX_W'(idx_q + IDX_W'(1));
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = upd;
    if (load_accept && (32'(entry_index_i) < 32'(MAX_ENTRIES))) begin
      wr_en             = 1'b1;
      wr_addr           = IDX_W'(entry_index_i);
      wr_data.mode      = entry_mode_i;
      wr_data.channel   = entry_channel_i;
      wr_data.momentary = entry_momentary_i;
      wr_data.latch     = 1'b0;
      wr_data.orient    = ORIENT_NONE;
      wr_data.start     = '0;
    end else if (step) begin
      wr_en = 1'b1;
    end
  end

  // Table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  // Sequencer and activity state next values.
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    n_d           = n_q;
    is_active_d   = is_active_q;
    is_inactive_d = is_inactive_q;
    out_valid_d   = out_valid_q && out_stall_i;
    if (tick_accept) begin
      if (inactivity_irq_i) begin
        is_active_d   = 1'b0;
        is_inactive_d = 1'b1;
      end
      if (activity_irq_i) begin
        is_active_d   = 1'b1;
        is_inactive_d = 1'b0;
      end
      idx_d = '0;
      n_d   = n_sel;
      if (n_sel != '0) begin
        state_d = S_EVAL;
      end
    end
    if (step) begin
      out_valid_d = 1'b1;
      idx_d       = IDX_W'(idx_q + IDX_W'(1));
      if (at_last) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      n_q           <= '0;
      is_active_q   <= 1'b0;
      is_inactive_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      n_q           <= n_d;
      is_active_q   <= is_active_d;
      is_inactive_q <= is_inactive_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Tick payload capture.
  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      accel_x_q <= accel_x_i;
      accel_y_q <= accel_y_i;
      accel_z_q <= accel_z_i;
      side_q    <= up_side_i;
      now_q     <= now_ms_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_channel_q <= rdata_q.channel;
      out_value_q   <= val;
      last_q        <= at_last;
    end
  end

  // The walk never addresses an entry beyond the count taken at the tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (CNT_W'(idx_q) < n_q))
    else $error("entry index beyond walk length");

  // A tick with entries to walk starts the walk in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_accept && (n_sel != '0)) |=> (state_q == S_EVAL) && (idx_q == '0))
    else $error("tick did not start the walk");

  // Leaving the walk always leaves the final result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && ($past(state_q) == S_EVAL)) |-> (out_valid_q && last_q))
    else $error("walk ended without a final result");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && (state_q == S_EVAL)) |=>
      (out_valid_q && $stable(idx_q)))
    else $error("walk advanced over a stalled result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion trigger channel mapper testbench
// Loads behavior entries and sends sensor ticks through the valid/stall input
// channel while the output side stalls on its own pattern. A predictor in the
// testbench mirrors the entry table and the activity state. Each result is
// compared field by field with the oldest expected channel value.
// ----------------------------------------------------------------------------
module tb_top;
  import mtcm_pkg::*;

  localparam int CLK_HALF_NS    = 10;
  localparam int TABLE_DEPTH    = 64;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS    = 10;

  // Modes and side codes that the package does not name.
  localparam logic [3:0] MODE_SIDE_B = 4'd6;
  localparam logic [3:0] MODE_SIDE_C = 4'd7;
  localparam logic [3:0] MODE_SIDE_D = 4'd8;
  localparam logic [3:0] MODE_TOP    = 4'd9;
  localparam logic [3:0] MODE_UNUSED = 4'd15;
  localparam logic [2:0] UP_A        = 3'd0;
  localparam logic [2:0] UP_TOP      = 3'd4;
  localparam logic [2:0] UP_BOTTOM   = 3'd5;
  localparam logic [2:0] UP_BAD_LO   = 3'd6;
  localparam logic [2:0] UP_BAD_HI   = 3'd7;

  // Receiver stall styles.
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  typedef struct {
    logic               func;
    logic [5:0]         index;
    logic [3:0]         mode;
    logic [5:0]         channel;
    logic               momentary;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               inactivity_irq;
    logic               activity_irq;
    logic [2:0]         up_side;
    logic [31:0]        now_ms;
  } sensor_item_t;

  typedef struct {
    logic [5:0] channel;
    logic [9:0] value;
    logic       is_last;
  } channel_value_t;

  // Clock, reset and block ports.
  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic func_i;
  logic [5:0] entry_index_i;
  logic [3:0] entry_mode_i;
  logic [5:0] entry_channel_i;
  logic entry_momentary_i;
  logic signed [15:0] accel_x_i;
  logic signed [15:0] accel_y_i;
  logic signed [15:0] accel_z_i;
  logic inactivity_irq_i;
  logic activity_irq_i;
  logic [2:0] up_side_i;
  logic [31:0] now_ms_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [5:0] out_channel_o;
  logic [9:0] out_value_o;
  logic last_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor state.
  entry_t         behavior_table[TABLE_DEPTH];
  logic           is_active;
  logic           is_inactive;
  logic [6:0]     list_length_cfg;
  logic [15:0]    pulse_ms_cfg;
  channel_value_t expected_values[$];

  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;
  logic [31:0] sensor_clock_ms = 32'd0;
  logic [2:0]  held_side = UP_A;

  motion_trigger_channel_mapper dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .entry_index_i    (entry_index_i),
    .entry_mode_i     (entry_mode_i),
    .entry_channel_i  (entry_channel_i),
    .entry_momentary_i(entry_momentary_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .inactivity_irq_i (inactivity_irq_i),
    .activity_irq_i   (activity_irq_i),
    .up_side_i        (up_side_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .out_value_o      (out_value_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // Axis reading clamped to the limits, doubled and offset.
  function automatic logic [9:0] scale_axis(logic signed [15:0] raw);
    int v;
    v = int'(raw);
    if (v > int'(AXIS_LIMIT_POS)) v = int'(AXIS_LIMIT_POS);
    if (v < int'(AXIS_LIMIT_NEG)) v = int'(AXIS_LIMIT_NEG);
    return 10'(v * 2 + int'(AXIS_OFFSET));
  endfunction

  // Trigger with a true condition: a level, or a one-shot that starts on the
  // first true tick and ends once the elapsed time passes pulse_ms.
  function automatic logic [9:0] trigger_value(int e, logic [31:0] now, logic already);
    logic [31:0] elapsed;
    if (!behavior_table[e].momentary) return FULL_VALUE;
    if (!already) begin
      behavior_table[e].start = now;
      return FULL_VALUE;
    end
    elapsed = now - behavior_table[e].start;
    return (elapsed > {16'b0, pulse_ms_cfg}) ? 10'd0 : FULL_VALUE;
  endfunction

  // Applies one accepted transaction to the predicted table and queues the
  // channel values a tick produces.
  task automatic map_channels(sensor_item_t it);
    int          walk;
    logic [3:0]  mode;
    logic [2:0]  target;
    logic [9:0]  val;
    logic        cond;
    if (it.func == FUNC_LOAD) begin
      behavior_table[it.index].mode      = it.mode;
      behavior_table[it.index].channel   = it.channel;
      behavior_table[it.index].momentary = it.momentary;
      behavior_table[it.index].latch     = 1'b0;
      behavior_table[it.index].orient    = ORIENT_NONE;
      behavior_table[it.index].start     = 32'd0;
    end else begin
      // Activity wins over inactivity when both interrupts are seen.
      if (it.inactivity_irq) begin
        is_active = 1'b0;
        is_inactive = 1'b1;
      end
      if (it.activity_irq) begin
        is_active = 1'b1;
        is_inactive = 1'b0;
      end
      walk = (int'(list_length_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(list_length_cfg);
      for (int e = 0; e < walk; e++) begin
        mode = behavior_table[e].mode;
        val = 10'd0;
        if (mode <= MODE_Z) begin
          val = scale_axis(mode == MODE_X ? it.accel_x :
                           mode == MODE_Y ? it.accel_y : it.accel_z);
        end else if (mode == MODE_ACTIVE || mode == MODE_INACTIVE) begin
          cond = (mode == MODE_ACTIVE) ? is_active : is_inactive;
          if (!cond) begin
            behavior_table[e].latch = 1'b0;
          end else begin
            val = trigger_value(e, it.now_ms, behavior_table[e].latch);
            if (behavior_table[e].momentary) behavior_table[e].latch = 1'b1;
          end
        end else if (mode <= MODE_BOTTOM) begin
          target = 3'(mode - MODE_SIDE_A);
          if (it.up_side != target) begin
            behavior_table[e].orient = it.up_side;
          end else begin
            val = trigger_value(e, it.now_ms, behavior_table[e].orient == target);
            if (behavior_table[e].momentary) behavior_table[e].orient = target;
          end
        end
        expected_values.push_back('{channel: behavior_table[e].channel, value: val,
                                    is_last: (e == walk - 1)});
      end
    end
  endtask

  function automatic sensor_item_t random_item();
    sensor_item_t it;
    it.func           = 1'($urandom_range(0, 1));
    it.index          = 6'($urandom_range(0, 63));
    it.mode           = 4'($urandom_range(0, 15));
    it.channel        = 6'($urandom_range(0, 63));
    it.momentary      = 1'($urandom_range(0, 1));
    it.accel_x        = 16'($urandom);
    it.accel_y        = 16'($urandom);
    it.accel_z        = 16'($urandom);
    it.inactivity_irq = 1'($urandom_range(0, 1));
    it.activity_irq   = 1'($urandom_range(0, 1));
    it.up_side        = 3'($urandom_range(0, 7));
    it.now_ms         = $urandom;
    return it;
  endfunction

  // Readings either anywhere in range or close to the clamp limits.
  function automatic logic signed [15:0] random_accel();
    int v;
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    v = int'($urandom_range(0, 700)) - 350;
    return v[15:0];
  endfunction

  // Sends one transaction. The sender works in bursts with random gaps.
  // Called at a rising edge, returns at the edge where it was accepted.
  task automatic send_item(sensor_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i        <= 1'b1;
    func_i            <= it.func;
    entry_index_i     <= it.index;
    entry_mode_i      <= it.mode;
    entry_channel_i   <= it.channel;
    entry_momentary_i <= it.momentary;
    accel_x_i         <= it.accel_x;
    accel_y_i         <= it.accel_y;
    accel_z_i         <= it.accel_z;
    inactivity_irq_i  <= it.inactivity_irq;
    activity_irq_i    <= it.activity_irq;
    up_side_i         <= it.up_side;
    now_ms_i          <= it.now_ms;
    do @(posedge clk_i); while (in_stall_o);
    map_channels(it);
  endtask

  task automatic load_entry(logic [5:0] idx, logic [3:0] mode, logic [5:0] ch, logic mom);
    sensor_item_t it;
    it = random_item();
    it.func = FUNC_LOAD;
    it.index = idx;
    it.mode = mode;
    it.channel = ch;
    it.momentary = mom;
    send_item(it);
  endtask

  task automatic send_tick(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] az, logic inact, logic act,
                           logic [2:0] side, logic [31:0] now);
    sensor_item_t it;
    it = random_item();
    it.func = FUNC_TICK;
    it.accel_x = ax;
    it.accel_y = ay;
    it.accel_z = az;
    it.inactivity_irq = inact;
    it.activity_irq = act;
    it.up_side = side;
    it.now_ms = now;
    send_item(it);
  endtask

  // Lowers valid, waits for every expected result and lets the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_LIST_LENGTH) list_length_cfg = data[6:0];
    else pulse_ms_cfg = data;
    @(posedge clk_i);
  endtask

  // Every mode once, axis extremes and the clamp edges, both interrupts,
  // out-of-range sides and a one-shot that runs out.
  task automatic test_directed_entries();
    write_register(REG_LIST_LENGTH, 16'd12);
    write_register(REG_PULSE_MS, PULSE_MS_RESET);
    load_entry(6'd0,  MODE_X,        6'd0,  1'b0);
    load_entry(6'd1,  MODE_Y,        6'd63, 1'b1);
    load_entry(6'd2,  MODE_Z,        6'd21, 1'b0);
    load_entry(6'd3,  MODE_ACTIVE,   6'd42, 1'b0);
    load_entry(6'd4,  MODE_INACTIVE, 6'd5,  1'b1);
    load_entry(6'd5,  MODE_SIDE_A,   6'd10, 1'b1);
    load_entry(6'd6,  MODE_SIDE_B,   6'd11, 1'b0);
    load_entry(6'd7,  MODE_SIDE_C,   6'd12, 1'b1);
    load_entry(6'd8,  MODE_SIDE_D,   6'd13, 1'b0);
    load_entry(6'd9,  MODE_TOP,      6'd14, 1'b1);
    load_entry(6'd10, MODE_BOTTOM,   6'd15, 1'b1);
    load_entry(6'd11, MODE_UNUSED,   6'd33, 1'b1);
    send_tick(16'sh7FFF, -16'sh8000, 16'sd0, 1'b0, 1'b0, UP_A, 32'd0);
    send_tick(16'sd250, -16'sd250, 16'sd251, 1'b1, 1'b1, UP_TOP, 32'd50);
    send_tick(-16'sd251, 16'sd1, -16'sd1, 1'b1, 1'b0, UP_A, 32'd100);
    send_tick(-16'sh8000, 16'sh7FFF, 16'sd249, 1'b0, 1'b0, UP_BAD_LO, 32'd150);
    send_tick(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, UP_BAD_HI, 32'd201);
    send_tick(16'sd1, -16'sd249, 16'sh7FFF, 1'b0, 1'b1, UP_A, 32'd250);
  endtask

  // Elapsed time across the 32-bit wrap, with the longest and shortest pulse.
  task automatic test_time_wrap();
    drain_results();
    write_register(REG_PULSE_MS, 16'hFFFF);
    send_tick(16'sd5, 16'sd6, 16'sd7, 1'b1, 1'b0, UP_BOTTOM, 32'hFFFF_FFF0);
    send_tick(16'sd5, 16'sd6, 16'sd7, 1'b1, 1'b0, UP_BOTTOM, 32'h0000_0010);
    drain_results();
    write_register(REG_PULSE_MS, 16'd0);
    send_tick(16'sd5, 16'sd6, 16'sd7, 1'b0, 1'b0, UP_BOTTOM, 32'h0000_0010);
    send_tick(16'sd5, 16'sd6, 16'sd7, 1'b0, 1'b0, UP_BOTTOM, 32'h0000_0011);
  endtask

  // Loads the rest of the table so that any list length is legal afterwards.
  task automatic test_fill_table();
    for (int i = 12; i < TABLE_DEPTH; i++) begin
      load_entry(6'(i), 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_output_backpressure();
    drain_results();
    write_register(REG_LIST_LENGTH, 16'd64);
    write_register(REG_PULSE_MS, 16'd100);
    hold_request = 1'b1;
    repeat (6) begin
      send_tick(random_accel(), random_accel(), random_accel(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), sensor_clock_ms);
      sensor_clock_ms += $urandom_range(0, 40);
    end
  endtask

  // Phases of random loads and ticks with a mostly advancing clock that now and then jumps.
  task automatic test_random_traffic();
    int           list_choice[5];
    int           pulse_choice[5];
    sensor_item_t it;
    list_choice  = '{64, 127, 0, -1, 1};
    pulse_choice = '{100, 0, 65535, -1, -1};
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_register(REG_LIST_LENGTH, (list_choice[p] < 0) ? 16'($urandom_range(1, 64))
                                                           : 16'(list_choice[p]));
      write_register(REG_PULSE_MS, (pulse_choice[p] < 0) ? 16'($urandom_range(0, 300))
                                                         : 16'(pulse_choice[p]));
      if (p == 1) sensor_clock_ms = 32'hFFFF_FF00;
      repeat (36) begin
        it = random_item();
        if ($urandom_range(0, 3) == 0) begin
          it.func = FUNC_LOAD;
          if ($urandom_range(0, 7) != 0) it.mode = 4'($urandom_range(MODE_X, MODE_BOTTOM));
        end else begin
          it.func = FUNC_TICK;
          if ($urandom_range(0, 15) == 0) sensor_clock_ms = $urandom;
          else sensor_clock_ms += $urandom_range(0, 60);
          it.now_ms = sensor_clock_ms;
          it.accel_x = random_accel();
          it.accel_y = random_accel();
          it.accel_z = random_accel();
          it.inactivity_irq = ($urandom_range(0, 3) == 0);
          it.activity_irq = ($urandom_range(0, 4) == 0);
          if ($urandom_range(0, 1) == 0) held_side = 3'($urandom_range(0, 7));
          it.up_side = held_side;
        end
        send_item(it);
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_LOAD;
    entry_index_i = '0;
    entry_mode_i = MODE_X;
    entry_channel_i = '0;
    entry_momentary_i = 1'b0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    inactivity_irq_i = 1'b0;
    activity_irq_i = 1'b0;
    up_side_i = UP_A;
    now_ms_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_LIST_LENGTH;
    cfg_data_i = '0;
    is_active = 1'b0;
    is_inactive = 1'b1;
    list_length_cfg = 7'd0;
    pulse_ms_cfg = PULSE_MS_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_entries();
    test_time_wrap();
    test_fill_table();
    test_output_backpressure();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Output stall: a long hold on request, otherwise styles that change now
  // and then, including stretches with no stall at all.
  initial begin : out_stall_driver
    int style;
    int style_left;
    int hold_left;
    style = STALL_NONE;
    style_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(STALL_NONE, STALL_TOGGLE);
          style_left = $urandom_range(40, 300);
        end
        style_left--;
        case (style)
          STALL_NONE: begin
            out_stall_i <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          STALL_HEAVY: begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall_i <= ~out_stall_i;
          end
        endcase
      end
    end
  end

  // Compares each accepted result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_checker
    channel_value_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_values.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: channel %0d value %0d last %0b",
                   out_channel_o, out_value_o, last_o);
        end
      end else begin
        want = expected_values.pop_front();
        if (out_channel_o !== want.channel || out_value_o !== want.value ||
            last_o !== want.is_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result mismatch: expected channel %0d value %0d last %0b, got %0d %0d %0b",
                     want.channel, want.value, want.is_last,
                     out_channel_o, out_value_o, last_o);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
